// ----- rtl/core/ffe_pkg.sv -----
// Shared types and constants for the field formula evaluator.
// Used by ffe_fpu, field_formula_evaluator, ffe_checker and testbench; depends on nothing else.
package ffe_pkg;

	localparam int DBL_W      = 64;
	localparam int MAX_TERMS  = 8;
	localparam int NUM_FIELDS = 10;
	localparam int IN_COUNT   = 10;
	localparam int PROG_W     = 46;
	localparam int TERMS_W    = 4;
	localparam int IDX_W      = 4;
	localparam int OP_W       = 2;
	localparam int PAIR_W     = OP_W + IDX_W;
	localparam int PROG_EXT_W = (IDX_W + PAIR_W * (MAX_TERMS - 1) > PROG_W) ?
		IDX_W + PAIR_W * (MAX_TERMS - 1) : PROG_W;
	localparam int EXP_W      = 14;
	localparam int RW         = 110;
	localparam int CFG_IDX_W  = 2;

	localparam logic [DBL_W-1:0] EPS_BITS  = 64'h3CD2_03AF_9EE7_5616;
	localparam logic [DBL_W-1:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [DBL_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_PROG  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_TERMS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_PROG  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEN_TERMS = 2'd3;

	typedef enum logic [OP_W-1:0] {
		FOP_ADD = 2'd0,
		FOP_SUB = 2'd1,
		FOP_MUL = 2'd2,
		FOP_DIV = 2'd3
	} fop_t;

	typedef struct packed {
		logic             start;
		fop_t             op;
		logic [DBL_W-1:0] a;
		logic [DBL_W-1:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic             done;
		logic [DBL_W-1:0] result;
	} fpu_rsp_t;

endpackage

// ----- rtl/core/ffe_fpu.sv -----
// Shared double-precision unit: add, subtract, multiply (shift-add) and
// divide (restoring), with one normalize/round sequencer. Uses ffe_pkg.
module ffe_fpu (
	input  logic                clk,
	input  logic                arst_n,
	input  ffe_pkg::fpu_req_t   req,
	output ffe_pkg::fpu_rsp_t   rsp
);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_DNORM = 5'b00010,
		F_MUL   = 5'b00100,
		F_DIV   = 5'b01000,
		F_NORM  = 5'b10000
	} fstate_t;

	localparam int RW = ffe_pkg::RW;
	localparam int EW = ffe_pkg::EXP_W;

	fstate_t                   state_q;
	logic                      sgn_q;
	logic signed [EW-1:0]      er_q;
	logic signed [EW-1:0]      eb_q;
	logic [RW-1:0]             r_q;
	logic [52:0]               ma_q;
	logic [52:0]               mb_q;
	logic [54:0]               rem_q;
	logic [5:0]                cnt_q;
	logic [63:0]               res_q;
	logic                      done_q;

	// operand unpack
	logic        sa, sb, sbr;
	logic [10:0] xa, xb, xa_u, xb_u;
	logic [51:0] fa, fb;
	logic [52:0] ma, mb;
	logic signed [EW-1:0] ea, eb;
	logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, sx;

	assign {sa, xa, fa} = req.a;
	assign {sbr, xb, fb} = req.b;
	assign sb = sbr ^ (req.op == ffe_pkg::FOP_SUB);
	assign sx = sa ^ sbr;
	assign xa_u = (xa == 11'd0) ? 11'd1 : xa;
	assign xb_u = (xb == 11'd0) ? 11'd1 : xb;
	assign ea = $signed({3'b000, xa_u});
	assign eb = $signed({3'b000, xb_u});
	assign ma = {xa != 11'd0, fa};
	assign mb = {xb != 11'd0, fb};
	assign nan_a  = (xa == 11'h7FF) && (fa != 52'd0);
	assign nan_b  = (xb == 11'h7FF) && (fb != 52'd0);
	assign inf_a  = (xa == 11'h7FF) && (fa == 52'd0);
	assign inf_b  = (xb == 11'h7FF) && (fb == 52'd0);
	assign zero_a = (xa == 11'd0) && (fa == 52'd0);
	assign zero_b = (xb == 11'd0) && (fb == 52'd0);

	// add path: align smaller magnitude with sticky, then add or subtract
	logic          a_ge, s_l, s_s;
	logic [10:0]   e_l, e_s, dsh;
	logic [52:0]   m_l, m_s;
	logic [RW-1:0] big_m, small_m, b_al, sum;
	logic          b_st, add_sgn;

	always_comb begin
		a_ge    = {xa, fa} >= {xb, fb};
		e_l     = a_ge ? xa_u : xb_u;
		e_s     = a_ge ? xb_u : xa_u;
		m_l     = a_ge ? ma : mb;
		m_s     = a_ge ? mb : ma;
		s_l     = a_ge ? sa : sb;
		s_s     = a_ge ? sb : sa;
		dsh     = e_l - e_s;
		big_m   = {1'b0, m_l, 56'd0};
		small_m = {1'b0, m_s, 56'd0};
		if (dsh >= 11'd110) begin
			b_al = '0;
			b_st = |m_s;
		end else begin
			b_al = small_m >> dsh;
			b_st = |(small_m & ~({RW{1'b1}} << dsh));
		end
		b_al = b_al | {{(RW-1){1'b0}}, b_st};
		sum  = (s_l == s_s) ? big_m + b_al : big_m - b_al;
		add_sgn = (sum == '0) ? (s_l & s_s) : s_l;
	end

	// multiply step
	logic [53:0]  mhi;
	logic [105:0] p_next;
	assign mhi    = {1'b0, r_q[105:53]} + (mb_q[0] ? {1'b0, ma_q} : 54'd0);
	assign p_next = {mhi, r_q[52:1]};

	// divide step
	logic        q_bit;
	logic [54:0] rem_sub;
	logic [56:0] q_fin;
	assign q_bit   = rem_q >= {2'b00, mb_q};
	assign rem_sub = q_bit ? rem_q - {2'b00, mb_q} : rem_q;
	assign q_fin   = {r_q[55:0], q_bit};

	// round to nearest even
	logic [52:0]          keep, mant;
	logic                 g_bit, st_bit, inc;
	logic [53:0]          m_rnd;
	logic signed [EW-1:0] er_r;
	logic [10:0]          e_fld;

	always_comb begin
		keep   = r_q[108:56];
		g_bit  = r_q[55];
		st_bit = |r_q[54:0];
		inc    = g_bit & (st_bit | keep[0]);
		m_rnd  = {1'b0, keep} + {53'd0, inc};
		mant   = m_rnd[53] ? m_rnd[53:1] : m_rnd[52:0];
		er_r   = er_q + $signed({{(EW-1){1'b0}}, m_rnd[53]});
		e_fld  = mant[52] ? er_r[10:0] : 11'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							ffe_pkg::FOP_ADD, ffe_pkg::FOP_SUB: begin
								if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
									res_q <= ffe_pkg::QNAN_BITS;
									done_q <= 1'b1;
								end else if (inf_a) begin
									res_q <= {sa, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (inf_b) begin
									res_q <= {sb, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else begin
									r_q     <= sum;
									er_q    <= $signed({3'b000, e_l});
									sgn_q   <= add_sgn;
									state_q <= F_NORM;
								end
							end
							ffe_pkg::FOP_MUL: begin
								if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
									res_q <= ffe_pkg::QNAN_BITS;
									done_q <= 1'b1;
								end else if (inf_a || inf_b) begin
									res_q <= {sx, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (zero_a || zero_b) begin
									res_q <= {sx, 63'd0};
									done_q <= 1'b1;
								end else begin
									r_q     <= '0;
									ma_q    <= ma;
									mb_q    <= mb;
									cnt_q   <= 6'd53;
									er_q    <= ea + eb - 14'sd1022;
									sgn_q   <= sx;
									state_q <= F_MUL;
								end
							end
							ffe_pkg::FOP_DIV: begin
								if (zero_b) begin
									res_q <= (nan_a || zero_a) ? ffe_pkg::QNAN_BITS :
										{sx, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (nan_a || nan_b || (inf_a && inf_b)) begin
									res_q <= ffe_pkg::QNAN_BITS;
									done_q <= 1'b1;
								end else if (inf_a) begin
									res_q <= {sx, 11'h7FF, 52'd0};
									done_q <= 1'b1;
								end else if (inf_b || zero_a) begin
									res_q <= {sx, 63'd0};
									done_q <= 1'b1;
								end else begin
									ma_q    <= ma;
									mb_q    <= mb;
									er_q    <= ea;
									eb_q    <= eb;
									sgn_q   <= sx;
									state_q <= F_DNORM;
								end
							end
						endcase
					end
				end
				F_DNORM: begin
					// bring subnormal operands to a leading one
					if (ma_q[52] && mb_q[52]) begin
						er_q    <= er_q - eb_q + 14'sd1023;
						rem_q   <= {2'b00, ma_q};
						r_q     <= '0;
						cnt_q   <= 6'd57;
						state_q <= F_DIV;
					end else begin
						if (!ma_q[52]) begin
							ma_q <= {ma_q[51:0], 1'b0};
							er_q <= er_q - 14'sd1;
						end
						if (!mb_q[52]) begin
							mb_q <= {mb_q[51:0], 1'b0};
							eb_q <= eb_q - 14'sd1;
						end
					end
				end
				F_MUL: begin
					mb_q  <= {1'b0, mb_q[52:1]};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						r_q     <= {1'b0, p_next, 3'b000};
						state_q <= F_NORM;
					end else begin
						r_q <= {4'd0, p_next};
					end
				end
				F_DIV: begin
					rem_q <= {rem_sub[53:0], 1'b0};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						r_q     <= {1'b0, q_fin, rem_sub != 55'd0, 51'd0};
						state_q <= F_NORM;
					end else begin
						r_q <= {r_q[RW-2:0], q_bit};
					end
				end
				F_NORM: begin
					priority if (r_q == '0) begin
						res_q   <= {sgn_q, 63'd0};
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end else if (r_q[RW-1]) begin
						r_q  <= {1'b0, r_q[RW-1:2], r_q[1] | r_q[0]};
						er_q <= er_q + 14'sd1;
					end else if (er_q < -14'sd128) begin
						// far below the subnormal range: only a sticky bit is left
						r_q  <= {{(RW-1){1'b0}}, 1'b1};
						er_q <= 14'sd1;
					end else if (er_q < 14'sd1) begin
						r_q  <= {1'b0, r_q[RW-1:2], r_q[1] | r_q[0]};
						er_q <= er_q + 14'sd1;
					end else if (!r_q[108] && (er_q > 14'sd1)) begin
						r_q  <= {r_q[RW-2:0], 1'b0};
						er_q <= er_q - 14'sd1;
					end else begin
						if (er_r >= 14'sd2047)
							res_q <= {sgn_q, 11'h7FF, 52'd0};
						else
							res_q <= {sgn_q, e_fld, mant[51:0]};
						done_q  <= 1'b1;
						state_q <= F_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

// ----- rtl/core/field_formula_evaluator.sv -----
// Field formula evaluator top level: config registers, term sequencer
// and output register around the shared unit ffe_fpu. Uses ffe_pkg.
//
// One point is taken at a time: in_stall is high from acceptance until the
// quotient has moved to the output register, which can still be waiting
// while the next point is taken. All work runs on the one shared double
// unit, so an item's time is the sum of its operations: an add or subtract
// also normalizes by left shifts after cancellation, a multiply works by
// shift and add before it is normalized, a divide first brings subnormal
// operands to a leading one; a divide term also runs the divisor bias add.
// The term sequencer adds its own states for each term and each item.
module field_formula_evaluator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [ffe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ffe_pkg::PROG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [63:0]                          field_0,
	input  logic [63:0]                          field_1,
	input  logic [63:0]                          field_2,
	input  logic [63:0]                          field_3,
	input  logic [63:0]                          field_4,
	input  logic [63:0]                          field_5,
	input  logic [63:0]                          field_6,
	input  logic [63:0]                          field_7,
	input  logic [63:0]                          field_8,
	input  logic [63:0]                          field_9,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [63:0]                          quotient
);

	localparam int TW = ffe_pkg::TERMS_W;
	localparam int NIN = ffe_pkg::IN_COUNT;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_LOAD  = 8'b0000_0010,
		S_TERM  = 8'b0000_0100,
		S_EPS   = 8'b0000_1000,
		S_WAIT  = 8'b0001_0000,
		S_FINAL = 8'b0010_0000,
		S_FWAIT = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [ffe_pkg::PROG_W-1:0]      num_prog_q, den_prog_q;
	logic [TW-1:0]                   num_terms_q, den_terms_q;
	logic [63:0]                     fld_q [NIN];
	logic [63:0]                     fin [NIN];
	logic                            phase_q;
	logic [TW-1:0]                   k_q, nt_q;
	logic [63:0]                     acc_q, num_q, den_q, quot_q;
	logic                            out_valid_q;

	ffe_pkg::fpu_req_t req;
	ffe_pkg::fpu_rsp_t rsp;

	assign fin[0] = field_0;
	assign fin[1] = field_1;
	assign fin[2] = field_2;
	assign fin[3] = field_3;
	assign fin[4] = field_4;
	assign fin[5] = field_5;
	assign fin[6] = field_6;
	assign fin[7] = field_7;
	assign fin[8] = field_8;
	assign fin[9] = field_9;

	// program decode for the current term
	logic [ffe_pkg::PROG_W-1:0]     prog;
	logic [ffe_pkg::PROG_EXT_W-1:0] prog_ext;
	logic [ffe_pkg::PAIR_W-1:0]     pair;
	ffe_pkg::fop_t                  op_sel;
	logic [ffe_pkg::IDX_W-1:0]      rd_idx;
	logic [63:0]                    rd_data;
	logic [TW-1:0]                  raw_terms, nt;

	always_comb begin
		prog     = phase_q ? den_prog_q : num_prog_q;
		prog_ext = ffe_pkg::PROG_EXT_W'(prog);
		pair     = prog_ext[ffe_pkg::IDX_W + ffe_pkg::PAIR_W * (int'(k_q) - 1) +: ffe_pkg::PAIR_W];
		op_sel   = ffe_pkg::fop_t'(pair[ffe_pkg::OP_W-1:0]);
		rd_idx   = (state_q == S_LOAD) ? prog[ffe_pkg::IDX_W-1:0] :
			pair[ffe_pkg::PAIR_W-1:ffe_pkg::OP_W];
		if ((int'(rd_idx) < ffe_pkg::NUM_FIELDS) && (int'(rd_idx) < NIN))
			rd_data = fld_q[rd_idx];
		else
			rd_data = '0;
		raw_terms = phase_q ? den_terms_q : num_terms_q;
		if (raw_terms > TW'(ffe_pkg::MAX_TERMS))
			nt = TW'(ffe_pkg::MAX_TERMS);
		else if (!phase_q && (raw_terms == '0))
			nt = TW'(1);
		else
			nt = raw_terms;
	end

	// requests to the shared unit
	always_comb begin
		req = '0;
		unique case (state_q)
			S_TERM: begin
				if (k_q < nt_q) begin
					req.start = 1'b1;
					if (op_sel == ffe_pkg::FOP_DIV) begin
						// bias the divisor first
						req.op = ffe_pkg::FOP_ADD;
						req.a  = rd_data;
						req.b  = ffe_pkg::EPS_BITS;
					end else begin
						req.op = op_sel;
						req.a  = acc_q;
						req.b  = rd_data;
					end
				end
			end
			S_EPS: begin
				req.start = rsp.done;
				req.op    = ffe_pkg::FOP_DIV;
				req.a     = acc_q;
				req.b     = rsp.result;
			end
			S_FINAL: begin
				req.start = 1'b1;
				req.op    = ffe_pkg::FOP_DIV;
				req.a     = num_q;
				req.b     = den_q;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	ffe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_prog_q  <= '0;
			num_terms_q <= TW'(1);
			den_prog_q  <= '0;
			den_terms_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ffe_pkg::REG_NUM_PROG:  num_prog_q  <= cfg_data;
				ffe_pkg::REG_NUM_TERMS: num_terms_q <= cfg_data[TW-1:0];
				ffe_pkg::REG_DEN_PROG:  den_prog_q  <= cfg_data;
				ffe_pkg::REG_DEN_TERMS: den_terms_q <= cfg_data[TW-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			for (int i = 0; i < NIN; i++)
				fld_q[i] <= fin[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= 1'b0;
			k_q         <= '0;
			nt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					acc_q   <= rd_data;
					k_q     <= TW'(1);
					nt_q    <= nt;
					state_q <= S_TERM;
				end
				S_TERM: begin
					if (k_q < nt_q) begin
						state_q <= (op_sel == ffe_pkg::FOP_DIV) ? S_EPS : S_WAIT;
					end else if (!phase_q) begin
						num_q <= acc_q;
						if (den_terms_q != '0) begin
							phase_q <= 1'b1;
							state_q <= S_LOAD;
						end else begin
							den_q   <= ffe_pkg::ONE_BITS;
							state_q <= S_FINAL;
						end
					end else begin
						den_q   <= acc_q;
						state_q <= S_FINAL;
					end
				end
				S_EPS: begin
					if (rsp.done)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.done) begin
						acc_q   <= rsp.result;
						k_q     <= k_q + TW'(1);
						state_q <= S_TERM;
					end
				end
				S_FINAL: begin
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					if (rsp.done) begin
						acc_q   <= rsp.result;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q) begin
						quot_q      <= acc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign quotient  = quot_q;

endmodule

// ----- bench/ffe_checker.sv -----
// Checker for the field formula evaluator: tracks the config writes, predicts
// each quotient with real arithmetic and compares it with the output beats.
// Depends on ffe_pkg.
module ffe_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ffe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffe_pkg::PROG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [9:0][63:0]              fields,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [63:0]                   quotient,
	output int                            errors,
	output int                            pending
);

	localparam int EXP_DEPTH = 16;

	logic [ffe_pkg::PROG_W-1:0]  num_prog, den_prog;
	logic [ffe_pkg::TERMS_W-1:0] num_cnt, den_cnt;
	logic [63:0]                 exp_mem [EXP_DEPTH];
	int                          wr_cnt = 0;
	int                          rd_cnt = 0;
	int                          err_cnt = 0;

	function automatic bit nan_bits(logic [63:0] b);
		return b[62:52] == 11'h7FF && b[51:0] != 0;
	endfunction

	// IEEE division with the zero-divisor case made explicit
	function automatic real fdiv(real x, real y);
		logic [63:0] xb, yb;
		xb = $realtobits(x);
		yb = $realtobits(y);
		if (yb[62:0] != 0)
			return x / y;
		if (nan_bits(xb) || xb[62:0] == 0)
			return $bitstoreal(ffe_pkg::QNAN_BITS);
		return $bitstoreal({xb[63] ^ yb[63], 11'h7FF, 52'd0});
	endfunction

	function automatic real eval_chain(logic [ffe_pkg::PROG_W-1:0] prog, int terms,
			real fv[16]);
		real acc, opd;
		ffe_pkg::fop_t op;
		int base;
		if (terms > ffe_pkg::MAX_TERMS)
			terms = ffe_pkg::MAX_TERMS;
		acc = fv[prog[3:0]];
		for (int k = 1; k < terms; k++) begin
			base = 4 + 6 * (k - 1);
			op = ffe_pkg::fop_t'(prog[base +: 2]);
			opd = fv[prog[base + 2 +: 4]];
			case (op)
				ffe_pkg::FOP_ADD: acc = acc + opd;
				ffe_pkg::FOP_SUB: acc = acc - opd;
				ffe_pkg::FOP_MUL: acc = acc * opd;
				default: acc = fdiv(acc, opd + $bitstoreal(ffe_pkg::EPS_BITS));
			endcase
		end
		return acc;
	endfunction

	function automatic logic [63:0] predict_quotient(logic [9:0][63:0] f);
		real fv[16];
		real num, den;
		logic [63:0] q;
		for (int i = 0; i < 16; i++)
			fv[i] = (i < ffe_pkg::NUM_FIELDS) ? $bitstoreal(f[i]) : 0.0;
		num = eval_chain(num_prog, (num_cnt == 0) ? 1 : int'(num_cnt), fv);
		den = (den_cnt == 0) ? 1.0 : eval_chain(den_prog, int'(den_cnt), fv);
		q = $realtobits(fdiv(num, den));
		return nan_bits(q) ? ffe_pkg::QNAN_BITS : q;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		err_cnt++;
	endtask

	assign errors  = err_cnt;
	assign pending = wr_cnt - rd_cnt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_prog <= '0;
			num_cnt  <= 4'd1;
			den_prog <= '0;
			den_cnt  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					ffe_pkg::REG_NUM_PROG:  num_prog <= cfg_data;
					ffe_pkg::REG_NUM_TERMS: num_cnt  <= cfg_data[ffe_pkg::TERMS_W-1:0];
					ffe_pkg::REG_DEN_PROG:  den_prog <= cfg_data;
					ffe_pkg::REG_DEN_TERMS: den_cnt  <= cfg_data[ffe_pkg::TERMS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (rd_cnt == wr_cnt)
					report("unexpected beat", quotient, '0);
				else begin
					if (quotient !== exp_mem[rd_cnt % EXP_DEPTH])
						report("quotient", quotient, exp_mem[rd_cnt % EXP_DEPTH]);
					rd_cnt++;
				end
			end
			if (in_valid && !in_stall) begin
				exp_mem[wr_cnt % EXP_DEPTH] = predict_quotient(fields);
				wr_cnt++;
			end
		end
	end
endmodule

// ----- bench/testbench.sv -----
// Top of the field formula evaluator bench: clock, reset, config phases,
// point stimulus with random gaps and output stalls, and the verdict.
// Depends on ffe_pkg, field_formula_evaluator and ffe_checker.
module testbench;

	localparam int LIMIT = 40000000;

	logic                          clk, arst_n;
	logic                          cfg_write;
	logic [ffe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ffe_pkg::PROG_W-1:0]    cfg_data;
	logic                          in_valid, in_stall;
	logic [9:0][63:0]              pt;
	logic                          out_valid, out_stall;
	logic [63:0]                   quotient;
	int                            errors, pending;
	int                            cycles = 0;

	field_formula_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.field_0(pt[0]), .field_1(pt[1]), .field_2(pt[2]), .field_3(pt[3]),
		.field_4(pt[4]), .field_5(pt[5]), .field_6(pt[6]), .field_7(pt[7]),
		.field_8(pt[8]), .field_9(pt[9]),
		.out_valid(out_valid), .out_stall(out_stall), .quotient(quotient)
	);

	ffe_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .fields(pt),
		.out_valid(out_valid), .out_stall(out_stall), .quotient(quotient),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		while (cycles < LIMIT)
			@(posedge clk);
		$display("field_formula_evaluator verification failed");
		$finish;
	end

	function automatic bit calm();
		return cycles > 40000 && cycles < 90000;
	endfunction

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (cycles >= 15000 && cycles < 18000)
				out_stall <= 1'b1;
			else
				out_stall <= !calm() && ($urandom_range(99) < 12);
		end
	end

	localparam logic [63:0] SPECIALS[10] = '{
		64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000,
		64'hBFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
		64'h7FF8_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
		64'hFFFF_FFFF_FFFF_FFFF};

	function automatic logic [63:0] rand_dbl();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return SPECIALS[$urandom_range(9)];
		if (sel == 1)
			return {$urandom, $urandom};
		return {1'($urandom), 11'(1023 - 20 + $urandom_range(40)), 20'($urandom), 32'($urandom)};
	endfunction

	task automatic write_reg(logic [ffe_pkg::CFG_IDX_W-1:0] idx,
			logic [ffe_pkg::PROG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic write_cfg(logic [ffe_pkg::PROG_W-1:0] np, logic [3:0] nt,
			logic [ffe_pkg::PROG_W-1:0] dp, logic [3:0] dt);
		write_reg(ffe_pkg::REG_NUM_PROG, np);
		write_reg(ffe_pkg::REG_NUM_TERMS, ffe_pkg::PROG_W'(nt));
		write_reg(ffe_pkg::REG_DEN_PROG, dp);
		write_reg(ffe_pkg::REG_DEN_TERMS, ffe_pkg::PROG_W'(dt));
		cfg_write <= 1'b0;
	endtask

	// offer one point; hold valid across back-to-back beats
	task automatic send_point(logic [9:0][63:0] p);
		int gap;
		gap = (!calm() && $urandom_range(99) < 12) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt       <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [ffe_pkg::PROG_W-1:0] rand_prog();
		return {14'($urandom), 32'($urandom)};
	endfunction

	initial begin
		logic [9:0][63:0] p;
		logic [ffe_pkg::PROG_W-1:0] np, dp;
		logic [3:0] nt, dt;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pt        = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: quotient is field 0 over a denominator of one
		for (int i = 0; i < 10; i++) begin
			for (int j = 0; j < 10; j++)
				p[j] = SPECIALS[(i + j) % 10];
			send_point(p);
		end
		drain();

		// sub, mul, div, add chain over a zero denominator (index 12 reads zero)
		write_cfg(ffe_pkg::PROG_W'({ffe_pkg::FOP_DIV, 4'd4, ffe_pkg::FOP_MUL, 4'd3,
				ffe_pkg::FOP_SUB, 4'd2, ffe_pkg::FOP_ADD, 4'd1, 4'd0}),
			4'd5, {36'd0, ffe_pkg::FOP_ADD, 4'd15, 4'd12}, 4'd1);
		for (int i = 0; i < 10; i++) begin
			for (int j = 0; j < 10; j++)
				p[j] = SPECIALS[(3 * i + j) % 10];
			send_point(p);
		end
		drain();

		for (int ph = 0; ph < 13; ph++) begin
			case (ph)
				0: begin np = '1; nt = 4'd15; dp = '1; dt = 4'd15; end
				1: begin np = '0; nt = 4'd0;  dp = '0; dt = 4'd8;  end
				2: begin np = rand_prog(); nt = 4'd8; dp = rand_prog(); dt = 4'd0; end
				default: begin
					np = rand_prog();
					nt = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 5));
					dp = rand_prog();
					dt = 4'($urandom_range(0, 4));
				end
			endcase
			write_cfg(np, nt, dp, dt);
			for (int n = 0; n < 105; n++) begin
				for (int j = 0; j < 10; j++)
					p[j] = rand_dbl();
				send_point(p);
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("field_formula_evaluator verification clean");
		else
			$display("field_formula_evaluator verification failed");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/ffe_pkg.sv
rtl/core/ffe_fpu.sv
rtl/core/field_formula_evaluator.sv
bench/ffe_checker.sv
bench/testbench.sv
